/* rtl/rrt_pkg.sv */
// Package for the request reassembly tracker: table size, disposition codes
// and the record that travels along the chain of table cells.
// No dependencies.
package rrt_pkg;

   localparam int TABLE_ENTRIES = 16;

   localparam int DISP_W  = 4;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 16;
   localparam int KEY_W   = 64;

   localparam logic [DISP_W-1:0] D_COMPLETE   = 4'd0;
   localparam logic [DISP_W-1:0] D_STORED_ACK = 4'd1;
   localparam logic [DISP_W-1:0] D_STORED     = 4'd2;
   localparam logic [DISP_W-1:0] D_CONTINUED  = 4'd3;
   localparam logic [DISP_W-1:0] D_REJECTED   = 4'd4;
   localparam logic [DISP_W-1:0] D_UNKNOWN    = 4'd5;
   localparam logic [DISP_W-1:0] D_OOO        = 4'd6;
   localparam logic [DISP_W-1:0] D_BAD_COUNT  = 4'd7;
   localparam logic [DISP_W-1:0] D_FULL       = 4'd8;

   // One packet header in flight through the cells, with its verdict so far.
   typedef struct packed {
      logic               active;
      logic               done;
      logic [KEY_W-1:0]   key;
      logic               first;
      logic               last;
      logic [COUNT_W-1:0] order;
      logic               raft;
      logic [DISP_W-1:0]  disp;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
   } query_type;

endpackage

/* rtl/rrt_cell.sv */
// One table entry of the request reassembly tracker together with its stage
// of the item chain. Depends on rrt_pkg.
module rrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rrt_pkg::SLOT_W-1:0]  cell_index,
   input  rrt_pkg::query_type          q_prev,
   output rrt_pkg::query_type          q_next
);

   logic                         valid_ff, valid_in;
   logic [rrt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [rrt_pkg::COUNT_W-1:0]  exp_ff, exp_in;
   logic [rrt_pkg::COUNT_W-1:0]  rcv_ff, rcv_in;
   rrt_pkg::query_type           q_ff, q_in;
   logic [rrt_pkg::COUNT_W-1:0]  after;

   assign after = rcv_ff + rrt_pkg::COUNT_W'(1);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      exp_in   = exp_ff;
      rcv_in   = rcv_ff;
      q_in     = q_prev;
      if (q_prev.active && !q_prev.done) begin
         if (q_prev.first) begin
            // A first packet takes the lowest free entry it meets.
            if (!valid_ff) begin
               valid_in   = 1'b1;
               key_in     = q_prev.key;
               exp_in     = q_prev.order;
               rcv_in     = rrt_pkg::COUNT_W'(1);
               q_in.done  = 1'b1;
               q_in.disp  = q_prev.raft ? rrt_pkg::D_STORED : rrt_pkg::D_STORED_ACK;
               q_in.slot  = cell_index;
               q_in.count = rrt_pkg::COUNT_W'(1);
            end
         end else if (valid_ff && (key_ff == q_prev.key)) begin
            rcv_in     = after;
            q_in.done  = 1'b1;
            q_in.slot  = cell_index;
            q_in.count = after;
            if (q_prev.order != rcv_ff) begin
               valid_in  = 1'b0;
               q_in.disp = rrt_pkg::D_OOO;
            end else if (!q_prev.last) begin
               q_in.disp = rrt_pkg::D_CONTINUED;
            end else begin
               valid_in  = 1'b0;
               q_in.disp = (after == exp_ff) ? rrt_pkg::D_COMPLETE : rrt_pkg::D_BAD_COUNT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      exp_ff <= exp_in;
      rcv_ff <= rcv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.active <= 1'b0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q_next = q_ff;

endmodule

/* rtl/request_reassembly_tracker.sv */
// Top level of the request reassembly tracker: input register, the chain of
// table cells and the result register. Depends on rrt_pkg and rrt_cell.
//
// Each item is one decoded packet header. It enters a head register and then
// walks the row of TABLE_ENTRIES cells, one cell per cycle; each cell holds
// one pending message (key of sender address, port and request id, expected
// and received counts) and settles the item when it owns or can take it. The
// result is registered at the end of the row, after the head register and
// each cell register in turn. One item is handled at a time: req_stall
// stays high from acceptance until the result has been taken.
// There is no clearing pass; the entry valid bits clear on reset.
module request_reassembly_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_src_ip,
   input  logic [15:0]                     req_src_port,
   input  logic [15:0]                     req_request_id,
   input  logic                            req_first_packet,
   input  logic                            req_last_packet,
   input  logic [15:0]                     req_packet_order,
   input  logic                            req_is_plain_request,
   input  logic                            req_is_raft,
   input  logic                            req_app_accepts,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rrt_pkg::DISP_W-1:0]      rsp_disposition,
   output logic [rrt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [rrt_pkg::COUNT_W-1:0]     rsp_received_count
);

   localparam int N = rrt_pkg::TABLE_ENTRIES;

   logic                          busy_ff, busy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rrt_pkg::DISP_W-1:0]    disp_ff, disp_in;
   logic [rrt_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [rrt_pkg::COUNT_W-1:0]   count_ff, count_in;
   rrt_pkg::query_type            head_ff, head_in;
   rrt_pkg::query_type            chain [N+1];
   rrt_pkg::query_type            tail;
   logic [N:0]                    chain_active;
   logic                          req_take, rsp_take;

   assign req_take = req_valid && !busy_ff;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // Rejected first packets and single-packet messages need no table entry and are settled before the item enters.
   always_comb begin
      head_in        = '0;
      head_in.active = req_take;
      head_in.key    = {req_src_ip, req_src_port, req_request_id};
      head_in.first  = req_first_packet;
      head_in.last   = req_last_packet;
      head_in.order  = req_packet_order;
      head_in.raft   = req_is_raft;
      if (req_first_packet) begin
         head_in.count = rrt_pkg::COUNT_W'(1);
         if (req_is_plain_request && !req_app_accepts) begin
            head_in.done = 1'b1;
            head_in.disp = rrt_pkg::D_REJECTED;
         end else if (req_last_packet) begin
            head_in.done = 1'b1;
            head_in.disp = (req_packet_order == rrt_pkg::COUNT_W'(1)) ?
                           rrt_pkg::D_COMPLETE : rrt_pkg::D_BAD_COUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.active <= 1'b0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < N; g++) begin : g_cell
      rrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (rrt_pkg::SLOT_W'(g)),
         .q_prev     (chain[g]),
         .q_next     (chain[g+1])
      );
   end

   for (genvar g = 0; g <= N; g++) begin : g_act
      assign chain_active[g] = chain[g].active;
   end

   assign tail = chain[N];

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      disp_in      = disp_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end
      if (rsp_take) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end
      if (tail.active) begin
         rsp_valid_in = 1'b1;
         if (tail.done) begin
            disp_in  = tail.disp;
            slot_in  = tail.slot;
            count_in = tail.count;
         end else if (tail.first) begin
            disp_in  = rrt_pkg::D_FULL;
            slot_in  = '0;
            count_in = rrt_pkg::COUNT_W'(1);
         end else begin
            disp_in  = rrt_pkg::D_UNKNOWN;
            slot_in  = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      disp_ff  <= disp_in;
      slot_ff  <= slot_in;
      count_ff <= count_in;
   end

   assign req_stall          = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_disposition    = disp_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_received_count = count_ff;

   a_single_item : assert property (@(posedge clock) disable iff (reset)
      $countones({chain_active, rsp_valid_ff}) <= 1)
      else $error("more than one item in flight");

   a_tail_result : assert property (@(posedge clock) disable iff (reset)
      tail.active |=> rsp_valid_ff)
      else $error("item left the cell row without a result");

   a_result_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("result shown with no item accepted");

   a_disp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (disp_ff <= rrt_pkg::D_FULL))
      else $error("disposition code out of range");

endmodule
